>>> rtl/lifo_id_free_list_allocator_assert.svh
// Assertion macros for the checker file of the ID allocator.
// No dependencies; include once per file that asserts.
`ifndef LIFO_ID_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define LIFO_ID_FREE_LIST_ALLOCATOR_ASSERT_SVH

// Property that must hold at every clock edge out of reset.
`define LFA_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define LFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/lfa_pkg.sv
// Shared constants and types for the LIFO slot ID allocator.
// No dependencies.
package lfa_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int ID_W      = 10;   // fixed width of slot IDs
    localparam int CNT_W     = 11;   // holds 0..MAX_SLOTS
    localparam int STATUS_W  = 3;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK           = 3'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID      = 3'd1;
    localparam logic [STATUS_W-1:0] STATUS_NONE_FREE    = 3'd2;
    localparam logic [STATUS_W-1:0] STATUS_BUSY_MAPPED  = 3'd3;
    localparam logic [STATUS_W-1:0] STATUS_ALREADY_FREE = 3'd4;

    // Request opcodes
    localparam logic OP_ALLOC   = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC
    } state_t;

    // Command broadcast to every stack cell
    typedef struct packed {
        logic load;   // reload initial ID
        logic push;   // take value from the cell above
        logic pop;    // take value from the cell below
    } cell_cmd_t;

endpackage

>>> rtl/lfa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module lfa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/lfa_stack_cell.sv
// One entry of the shifting free stack.
// Depends on lfa_pkg (ID_W, cell_cmd_t).
module lfa_stack_cell
    import lfa_pkg::*;
(
    input  logic            clk,
    input  cell_cmd_t       cmd,
    input  logic [ID_W-1:0] above,     // neighbor nearer the top
    input  logic [ID_W-1:0] below,     // neighbor farther from the top
    input  logic [ID_W-1:0] init_id,   // ID this cell holds after a refill
    output logic [ID_W-1:0] value
);

    logic [ID_W-1:0] value_reg;
    logic [ID_W-1:0] value_next;

    // Load beats push beats pop; otherwise hold
    always_comb
    begin
        value_next = value_reg;
        if (cmd.load)
        begin
            value_next = init_id;
        end
        else if (cmd.push)
        begin
            value_next = above;
        end
        else if (cmd.pop)
        begin
            value_next = below;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

>>> rtl/lifo_id_free_list_allocator.sv
// LIFO slot ID allocator: top level with controller, stack cell chain and mark RAM.
// Depends on lfa_pkg, lfa_stack_cell, lfa_ram.
//
// Usage:
//   Requests arrive on s_*: s_tuser is the opcode (0 allocate, 1 release),
//   s_tdata carries the ID to release and the caller's mapped flag.
//   Each request yields one result on m_*: granted ID, status, stack full
//   flag and the number of free IDs left.
//   A request is taken when s_tvalid and s_tready are high. Its result is
//   registered when ST_EXEC fires; requests are not taken back to back, as the block
//   waits in ST_EXEC, with s_tready low, for the registered read of the in-use mark RAM.
//   The result sits in an output register; the next request is accepted
//   while it waits, but is not finished until m_tready frees that register.
//   The free stack is a chain of cells with the top in cell 0; it pushes and
//   pops by shifting all cells one place.
//   After reset, and after each write of pool_size, the block runs a
//   clearing pass over every entry of the mark RAM with s_tready low; the
//   stack is refilled so that the first allocation returns ID 0. A
//   pool_size write of 0 is ignored, values above 1024 saturate.
module lifo_id_free_list_allocator
    import lfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             pool_size_we,
    input  logic [CNT_W-1:0] pool_size_wdata,
    // request channel
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [15:0]      s_tdata,   // [9:0] slot_id, [10] slot_mapped
    input  logic             s_tuser,   // [0] op
    // result channel
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata    // [9:0] granted_id, [12:10] status,
                                        // [13] stack_full_error, [24:14] free_left
);

    localparam logic [ID_W-1:0]  LAST_IDX = ID_W'(MAX_SLOTS - 1);
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_SLOTS);
    localparam int               OUT_PAD  = 32 - (ID_W + STATUS_W + 1 + CNT_W);

    // Control state
    state_t           state_reg, state_next;
    logic [ID_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [CNT_W-1:0] pool_size_reg, pool_size_next;
    logic [CNT_W-1:0] depth_reg, depth_next;
    logic             m_valid_reg, m_valid_next;

    // Captured request
    logic             req_op_reg;
    logic [ID_W-1:0]  req_id_reg;
    logic             req_mapped_reg;

    // Result payload
    logic [ID_W-1:0]     out_granted_reg, out_granted_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_full_reg, out_full_next;
    logic [CNT_W-1:0]    out_left_reg, out_left_next;

    // Datapath wires
    cell_cmd_t        cell_cmd;
    logic [ID_W-1:0]  cell_val [MAX_SLOTS];
    logic             ram_we;
    logic [ID_W-1:0]  ram_waddr;
    logic             ram_wdata;
    logic [ID_W-1:0]  ram_raddr;
    logic             mark;
    logic             out_free;
    logic             fire;
    logic             cfg_take;
    logic [CNT_W-1:0] cfg_size;

    logic alloc_ok, none_free, invalid_id, busy, already_free, full_err, release_ok;

    // Configuration write: ignore zero, saturate at the pool maximum
    assign cfg_take = pool_size_we && (pool_size_wdata != '0);
    assign cfg_size = (pool_size_wdata > MAX_CNT) ? MAX_CNT : pool_size_wdata;

    assign out_free = !m_valid_reg || m_tready;
    assign fire     = (state_reg == ST_EXEC) && out_free;

    // Request decode against the current state
    always_comb
    begin
        alloc_ok     = (req_op_reg == OP_ALLOC) && (depth_reg != '0);
        none_free    = (req_op_reg == OP_ALLOC) && (depth_reg == '0);
        invalid_id   = (req_op_reg == OP_RELEASE) && ({1'b0, req_id_reg} >= pool_size_reg);
        busy         = (req_op_reg == OP_RELEASE) && !invalid_id && req_mapped_reg;
        already_free = (req_op_reg == OP_RELEASE) && !invalid_id && !req_mapped_reg && !mark;
        full_err     = (req_op_reg == OP_RELEASE) && !invalid_id && !req_mapped_reg && mark
                       && (depth_reg >= pool_size_reg);
        release_ok   = (req_op_reg == OP_RELEASE) && !invalid_id && !req_mapped_reg && mark
                       && (depth_reg < pool_size_reg);
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (cfg_take)
        begin
            state_next = ST_CLEAR;
        end
    end

    // Control outputs: handshake, cell command, mark RAM ports
    always_comb
    begin
        s_tready  = 1'b0;
        cell_cmd  = '0;
        ram_we    = 1'b0;
        ram_waddr = req_id_reg;
        ram_wdata = 1'b0;
        ram_raddr = req_id_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cell_cmd.load = 1'b1;
                ram_we        = 1'b1;
                ram_waddr     = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                s_tready  = 1'b1;
                ram_raddr = s_tdata[ID_W-1:0];
            end
            ST_EXEC:
            begin
                if (fire && alloc_ok)
                begin
                    cell_cmd.pop = 1'b1;
                    ram_we       = 1'b1;
                    ram_waddr    = cell_val[0];
                    ram_wdata    = 1'b1;
                end
                else if (fire && release_ok)
                begin
                    cell_cmd.push = 1'b1;
                    ram_we        = 1'b1;
                end
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Counters, depth and result payload
    always_comb
    begin
        clr_cnt_next     = clr_cnt_reg + 1'b1;
        pool_size_next   = pool_size_reg;
        depth_next       = depth_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        out_granted_next = out_granted_reg;
        out_status_next  = out_status_reg;
        out_full_next    = out_full_reg;
        out_left_next    = out_left_reg;
        if (fire)
        begin
            if (alloc_ok)
            begin
                depth_next = depth_reg - 1'b1;
            end
            else if (release_ok)
            begin
                depth_next = depth_reg + 1'b1;
            end
            m_valid_next     = 1'b1;
            out_granted_next = alloc_ok ? cell_val[0] : '0;
            out_full_next    = full_err;
            out_left_next    = depth_next;
            if (none_free)
            begin
                out_status_next = STATUS_NONE_FREE;
            end
            else if (invalid_id)
            begin
                out_status_next = STATUS_INVALID;
            end
            else if (busy)
            begin
                out_status_next = STATUS_BUSY_MAPPED;
            end
            else if (already_free)
            begin
                out_status_next = STATUS_ALREADY_FREE;
            end
            else
            begin
                out_status_next = STATUS_OK;
            end
        end
        if (cfg_take)
        begin
            clr_cnt_next   = '0;
            pool_size_next = cfg_size;
            depth_next     = cfg_size;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            pool_size_reg <= MAX_CNT;
            depth_reg     <= MAX_CNT;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            pool_size_reg <= pool_size_next;
            depth_reg     <= depth_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            req_op_reg     <= s_tuser;
            req_id_reg     <= s_tdata[ID_W-1:0];
            req_mapped_reg <= s_tdata[ID_W];
        end
        out_granted_reg <= out_granted_next;
        out_status_reg  <= out_status_next;
        out_full_reg    <= out_full_next;
        out_left_reg    <= out_left_next;
    end

    // Free stack: chain of cells, cell 0 is the top
    for (genvar k = 0; k < MAX_SLOTS; k++)
    begin : g_cell
        logic [ID_W-1:0] above_val;
        logic [ID_W-1:0] below_val;

        if (k == 0)
        begin : g_top
            assign above_val = req_id_reg;
        end
        else
        begin : g_mid
            assign above_val = cell_val[k-1];
        end

        if (k == MAX_SLOTS - 1)
        begin : g_bottom
            assign below_val = '0;
        end
        else
        begin : g_inner
            assign below_val = cell_val[k+1];
        end

        lfa_stack_cell u_cell (
            .clk     (clk),
            .cmd     (cell_cmd),
            .above   (above_val),
            .below   (below_val),
            .init_id (ID_W'(k)),
            .value   (cell_val[k])
        );
    end

    // In-use marks
    lfa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_marks (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (mark)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{OUT_PAD{1'b0}}, out_left_reg, out_full_reg,
                       out_status_reg, out_granted_reg};

endmodule

>>> rtl/lfa_checker.sv
// Port-level checker for the LIFO slot ID allocator, bound to the top level.
// Depends on lfa_pkg and lifo_id_free_list_allocator_assert.svh.
`include "lifo_id_free_list_allocator_assert.svh"

module lfa_checker
    import lfa_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [31:0]      m_tdata
);

    logic [ID_W-1:0]     res_id;
    logic [STATUS_W-1:0] res_status;
    logic                res_full;
    logic [CNT_W-1:0]    res_left;

    assign res_id     = m_tdata[ID_W-1:0];
    assign res_status = m_tdata[ID_W+STATUS_W-1:ID_W];
    assign res_full   = m_tdata[ID_W+STATUS_W];
    assign res_left   = m_tdata[ID_W+STATUS_W+CNT_W:ID_W+STATUS_W+1];

    // Status code is a defined one
    `LFA_ASSERT_ALWAYS(a_status_range, !m_tvalid || res_status == STATUS_OK || res_status == STATUS_INVALID || res_status == STATUS_NONE_FREE || res_status == STATUS_BUSY_MAPPED || res_status == STATUS_ALREADY_FREE, "undefined status code")

    // Full stack refusal only comes with an ok status and no granted ID
    `LFA_ASSERT_ALWAYS(a_full_ok, !(m_tvalid && res_full) || (res_status == STATUS_OK && res_id == '0), "stack full flag with bad status or ID")

    // Free count never exceeds the pool maximum
    `LFA_ASSERT_ALWAYS(a_left_range, !m_tvalid || res_left <= CNT_W'(MAX_SLOTS), "free count above maximum")

    // A stalled result holds
    `LFA_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // One request at a time: ready drops right after an accept
    `LFA_ASSERT_NEXT(a_one_req, s_tvalid && s_tready, !s_tready, "request accepted back to back")

endmodule

bind lifo_id_free_list_allocator lfa_checker u_lfa_checker (.*);

>>> tb/alloc_result_checker.sv
// Result checker for the LIFO slot ID allocator: follows config writes and requests,
// predicts each result and compares it with what the block returns.
// Depends on lfa_pkg.
module alloc_result_checker
    import lfa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             pool_size_we,
    input  logic [CNT_W-1:0] pool_size_wdata,
    input  logic             s_tvalid,
    input  logic             s_tready,
    input  logic [15:0]      s_tdata,   // [9:0] slot_id, [10] slot_mapped
    input  logic             s_tuser,   // [0] op
    input  logic             m_tvalid,
    input  logic             m_tready,
    input  logic [31:0]      m_tdata,   // [9:0] granted_id, [12:10] status,
                                        // [13] stack_full_error, [24:14] free_left
    output int               outstanding,
    output int               mismatch_count
);

    typedef struct packed {
        logic [ID_W-1:0]     granted_id;
        logic [STATUS_W-1:0] status;
        logic                stack_full;
        logic [CNT_W-1:0]    free_left;
    } alloc_result_t;

    // Shadow of the pool
    int              pool_cnt;
    int              free_cnt;
    logic [ID_W-1:0] id_stack [MAX_SLOTS];
    bit              in_use [MAX_SLOTS];

    alloc_result_t   expected_results [$];
    int              n_bad;

    // Refill so that the first allocation pops ID 0; all marks cleared
    function automatic void restart_pool(int size);
        int i;
        for (i = 0; i < MAX_SLOTS; i++)
        begin
            id_stack[i] = (i < size) ? ID_W'(size - 1 - i) : '0;
            in_use[i]   = 1'b0;
        end
        pool_cnt = size;
        free_cnt = size;
    endfunction

    function automatic alloc_result_t serve_request(logic op, logic [ID_W-1:0] id,
                                                    logic mapped);
        alloc_result_t r;
        r        = '0;
        r.status = STATUS_OK;
        if (op == OP_ALLOC)
        begin
            if (free_cnt == 0)
                r.status = STATUS_NONE_FREE;
            else
            begin
                free_cnt--;
                r.granted_id         = id_stack[free_cnt];
                in_use[r.granted_id] = 1'b1;
            end
        end
        // release checks: range, mapped, already free, stack full
        else if (int'(id) >= pool_cnt)
            r.status = STATUS_INVALID;
        else if (mapped)
            r.status = STATUS_BUSY_MAPPED;
        else if (!in_use[id])
            r.status = STATUS_ALREADY_FREE;
        else if (free_cnt >= pool_cnt)
            r.stack_full = 1'b1;
        else
        begin
            in_use[id]         = 1'b0;
            id_stack[free_cnt] = id;
            free_cnt++;
        end
        r.free_left = CNT_W'(free_cnt);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t got;
        alloc_result_t want;
        int            wsize;
        if (!rst_n)
        begin
            restart_pool(MAX_SLOTS);
            expected_results.delete();
            n_bad          = 0;
            outstanding    <= 0;
            mismatch_count <= 0;
        end
        else
        begin
            // pool size write: zero ignored, oversize saturates
            if (pool_size_we && pool_size_wdata != '0)
            begin
                wsize = int'(pool_size_wdata);
                restart_pool((wsize > MAX_SLOTS) ? MAX_SLOTS : wsize);
            end

            if (s_tvalid && s_tready)
                expected_results.push_back(serve_request(s_tuser, s_tdata[ID_W-1:0],
                                                         s_tdata[ID_W]));

            if (m_tvalid && m_tready)
            begin
                got.granted_id = m_tdata[9:0];
                got.status     = m_tdata[12:10];
                got.stack_full = m_tdata[13];
                got.free_left  = m_tdata[24:14];
                if (expected_results.size() == 0)
                begin
                    n_bad++;
                    if (n_bad <= 10)
                        $display("unexpected result: granted=%0d st=%0d full=%0d free=%0d",
                                 got.granted_id, got.status, got.stack_full, got.free_left);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.granted_id != want.granted_id || got.status != want.status ||
                        got.stack_full != want.stack_full || got.free_left != want.free_left)
                    begin
                        n_bad++;
                        if (n_bad <= 10)
                        begin
                            $write("mismatch: expected granted=%0d st=%0d full=%0d free=%0d, ",
                                   want.granted_id, want.status, want.stack_full,
                                   want.free_left);
                            $display("got granted=%0d st=%0d full=%0d free=%0d",
                                     got.granted_id, got.status, got.stack_full,
                                     got.free_left);
                        end
                    end
                end
            end

            outstanding    <= expected_results.size();
            mismatch_count <= n_bad;
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the allocator testbench: clock, reset, request and config stimulus, verdict.
// Depends on lfa_pkg, lifo_id_free_list_allocator and alloc_result_checker.
module testbench;
    import lfa_pkg::*;

    logic             clk             = 1'b0;
    logic             rst_n           = 1'b0;
    logic             pool_size_we    = 1'b0;
    logic [CNT_W-1:0] pool_size_wdata = '0;
    logic             s_tvalid        = 1'b0;
    logic             s_tready;
    logic [15:0]      s_tdata         = '0;   // [9:0] slot_id, [10] slot_mapped
    logic             s_tuser         = 1'b0; // [0] op
    logic             m_tvalid;
    logic             m_tready        = 1'b0;
    logic [31:0]      m_tdata;                // [9:0] granted_id, [12:10] status,
                                              // [13] stack_full_error, [24:14] free_left
    int               outstanding;
    int               mismatch_count;

    // Stimulus shaping state
    bit               idle_on = 1'b0;
    int               stall_left = 0;
    int               cur_pool = MAX_SLOTS;
    logic [ID_W-1:0]  held_ids [$];
    logic             sent_ops [$];

    always #2 clk = ~clk;

    lifo_id_free_list_allocator i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .pool_size_we    (pool_size_we),
        .pool_size_wdata (pool_size_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata)
    );

    alloc_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .pool_size_we    (pool_size_we),
        .pool_size_wdata (pool_size_wdata),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .outstanding     (outstanding),
        .mismatch_count  (mismatch_count)
    );

    // Result side: random stall bursts while idling is enabled
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // Collect granted IDs so releases can target slots actually in use
    always @(posedge clk)
    begin
        logic op;
        if (m_tvalid && m_tready && sent_ops.size() != 0)
        begin
            op = sent_ops.pop_front();
            if (op == OP_ALLOC && m_tdata[12:10] == STATUS_OK)
                held_ids.push_back(m_tdata[ID_W-1:0]);
        end
    end

    task automatic send_request(input logic op, input logic [ID_W-1:0] id,
                                input logic mapped);
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'b0, mapped, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sent_ops.push_back(op);
    endtask

    // Hold off requests until every result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic write_pool(input logic [CNT_W-1:0] value);
        drain();
        repeat (4) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pool_size_we    <= 1'b1;
        pool_size_wdata <= value;
        @(posedge clk);
        pool_size_we    <= 1'b0;
        if (value != '0)
        begin
            cur_pool = (int'(value) > MAX_SLOTS) ? MAX_SLOTS : int'(value);
            held_ids.delete();
        end
    endtask

    // Mostly legal alloc/release traffic, some noise and stray releases
    task automatic send_random_item(input int release_pct);
        int              k;
        logic [ID_W-1:0] id;
        logic            mapped;
        id     = ID_W'($urandom_range(0, MAX_SLOTS - 1));
        mapped = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 9) == 0)
            send_request(1'($urandom_range(0, 1)), id, mapped);
        else if ($urandom_range(0, 19) == 0)
            send_request(OP_RELEASE, ID_W'($urandom_range(0, cur_pool - 1)), 1'b0);
        else if (held_ids.size() != 0 && $urandom_range(0, 99) < release_pct)
        begin
            k      = $urandom_range(0, held_ids.size() - 1);
            id     = held_ids[k];
            mapped = ($urandom_range(0, 6) == 0);
            if (!mapped)
                held_ids.delete(k);
            send_request(OP_RELEASE, id, mapped);
        end
        else
            send_request(OP_ALLOC, id, mapped);
    endtask

    initial
    begin
        logic [CNT_W-1:0] pool_plan [11];
        logic [CNT_W-1:0] value;
        int               p;
        int               n;
        int               release_pct;
        pool_plan = '{11'd1, 11'd2047, 11'd0, 11'd5, 11'd1024, 11'd3,
                      11'd2, 11'd40, 11'd17, 11'd1, 11'd9};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: full reset-size pool
        send_request(OP_ALLOC,   10'd0,    1'b0);
        send_request(OP_ALLOC,   10'd1023, 1'b1);
        send_request(OP_ALLOC,   10'd0,    1'b0);
        send_request(OP_RELEASE, 10'd1,    1'b1);   // busy mapped
        send_request(OP_RELEASE, 10'd1,    1'b0);
        send_request(OP_RELEASE, 10'd1,    1'b0);   // already free
        send_request(OP_RELEASE, 10'd1023, 1'b0);   // never allocated
        send_request(OP_ALLOC,   10'd0,    1'b0);

        // Directed: two-slot pool, exhaustion and range checks
        write_pool(11'd2);
        send_request(OP_ALLOC,   10'd0,    1'b0);
        send_request(OP_ALLOC,   10'd0,    1'b0);
        send_request(OP_ALLOC,   10'd0,    1'b0);   // none free
        send_request(OP_RELEASE, 10'd2,    1'b0);   // out of range
        send_request(OP_RELEASE, 10'd1023, 1'b1);   // range wins over mapped
        send_request(OP_RELEASE, 10'd0,    1'b1);
        send_request(OP_RELEASE, 10'd0,    1'b0);
        send_request(OP_RELEASE, 10'd1,    1'b0);
        send_request(OP_RELEASE, 10'd1,    1'b0);
        send_request(OP_ALLOC,   10'd0,    1'b0);

        // Random phases, each opening with a pool size write; last phase runs without idling
        for (p = 0; p < 11; p++)
        begin
            value = (p % 4 == 3) ? CNT_W'($urandom_range(3, 64)) : pool_plan[p];
            write_pool(value);
            idle_on     = (p != 10) && ($urandom_range(0, 3) != 0);
            release_pct = $urandom_range(25, 60);
            for (n = 0; n < 103; n++)
            begin
                if ($urandom_range(0, 59) == 0)
                    drain();
                send_random_item(release_pct);
            end
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2000000;
        $display("status: fail");
        $finish;
    end

endmodule
